[design/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clk, rst, cond)
`define ASSERT_NEXT(name, clk, rst, ante, cons)
`define ASSERT_IMPLIES(name, clk, rst, ante, cons)

`endif

`endif

[design/trq_pkg.sv]
`default_nettype none

package trq_pkg;

   // command codes carried by a request transaction
   typedef enum logic [2:0] {
      OP_ENQUEUE = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_EXTRACT = 3'd2,
      OP_REMOVE  = 3'd3,
      OP_PEEK    = 3'd4,
      OP_COUNT   = 3'd5
   } opcode_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // command broadcast to every slot cell
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_ROTATE,
      CELL_DROP
   } cell_cmd_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP
   } state_type;

endpackage

`default_nettype wire

[design/trq_cell.sv]
`default_nettype none

module trq_cell
   import trq_pkg::*;
#(
   parameter int INDEX          = 0,
   parameter int COUNT_W        = 5,
   parameter int ID_WIDTH       = 8,
   parameter int PRIORITY_WIDTH = 8
) (
   input  wire logic                      clock,
   input  wire cell_cmd_type              cmd,
   input  wire logic [COUNT_W-1:0]        count,
   input  wire logic [ID_WIDTH-1:0]       wr_id,
   input  wire logic [PRIORITY_WIDTH-1:0] wr_pri,
   input  wire logic [ID_WIDTH-1:0]       next_id,
   input  wire logic [PRIORITY_WIDTH-1:0] next_pri,
   input  wire logic [ID_WIDTH-1:0]       wrap_id,
   input  wire logic [PRIORITY_WIDTH-1:0] wrap_pri,
   output logic [ID_WIDTH-1:0]            id,
   output logic [PRIORITY_WIDTH-1:0]      pri
);

   logic [ID_WIDTH-1:0]       id_ff,  id_in;
   logic [PRIORITY_WIDTH-1:0] pri_ff, pri_in;
   logic                      at_tail;
   logic                      is_last;

   // position of this slot relative to the fill level
   assign at_tail = (count == COUNT_W'(INDEX));
   assign is_last = (count == COUNT_W'(INDEX + 1));

   // slot update: hold, load at the tail, shift toward the head, or wrap the head round
   always_comb begin
      id_in  = id_ff;
      pri_in = pri_ff;
      unique case (cmd)
         CELL_HOLD: begin
         end
         CELL_WRITE: begin
            if (at_tail) begin
               id_in  = wr_id;
               pri_in = wr_pri;
            end
         end
         CELL_ROTATE: begin
            if (is_last) begin
               id_in  = wrap_id;
               pri_in = wrap_pri;
            end else begin
               id_in  = next_id;
               pri_in = next_pri;
            end
         end
         CELL_DROP: begin
            id_in  = next_id;
            pri_in = next_pri;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      pri_ff <= pri_in;
   end

   assign id  = id_ff;
   assign pri = pri_ff;

endmodule

`default_nettype wire

[design/task_ready_queue_fifo_priority.sv]
// task ready queue: a bounded queue of (id, priority) entries in arrival order
//
// request channel (req_valid / req_stall) carries an opcode, a task id and a
// priority; every accepted transaction gives exactly one response transaction
// on rsp_valid / rsp_stall with status, id, priority, count and empty flag.
// enqueue, dequeue, peek, count: result registered in the cycle after acceptance,
// one transaction per cycle sustained while the response side does not stall.
// remove by id: the slot cells rotate the queue once past the head compare
// and drop the first match on the way.
// extract highest priority: one rotation finds the maximum (ties to the
// entry nearest the head), a second rotation drops it.
// no new request is taken while a remove or extract is in progress.
// reset clears the fill count and the response valid flag; the queue is empty.
// a stalled response holds in the output register; a request is still taken
// in the cycle that the pending response is taken.
`default_nettype none

module task_ready_queue_fifo_priority
   import trq_pkg::*;
#(
   parameter int DEPTH          = 16,
   parameter int ID_WIDTH       = 8,
   parameter int PRIORITY_WIDTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [2:0]                 req_opcode,
   input  wire logic [ID_WIDTH-1:0]        req_task_id,
   input  wire logic [PRIORITY_WIDTH-1:0]  req_task_priority,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [ID_WIDTH-1:0]             rsp_out_task_id,
   output logic [PRIORITY_WIDTH-1:0]       rsp_out_priority,
   output logic [$clog2(DEPTH+1)-1:0]      rsp_entry_count,
   output logic                            rsp_is_empty
);

`include "assert_macros.svh"

   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W   = $clog2(DEPTH);

   // slot chain
   logic [ID_WIDTH-1:0]       cell_id  [DEPTH];
   logic [PRIORITY_WIDTH-1:0] cell_pri [DEPTH];
   logic [ID_WIDTH-1:0]       nxt_id   [DEPTH];
   logic [PRIORITY_WIDTH-1:0] nxt_pri  [DEPTH];
   cell_cmd_type              cmd;

   // sequencer state
   state_type                 state_ff, state_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        len_ff, len_in;
   logic [IDX_W-1:0]          step_ff, step_in;
   logic [IDX_W-1:0]          best_idx_ff, best_idx_in;
   logic [ID_WIDTH-1:0]       best_id_ff, best_id_in;
   logic [PRIORITY_WIDTH-1:0] best_pri_ff, best_pri_in;
   logic                      found_ff, found_in;
   logic                      extract_ff, extract_in;
   logic [ID_WIDTH-1:0]       key_ff, key_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [ID_WIDTH-1:0]       rsp_id_ff, rsp_id_in;
   logic [PRIORITY_WIDTH-1:0] rsp_pri_ff, rsp_pri_in;
   logic [COUNT_W-1:0]        rsp_count_ff;
   logic                      rsp_load;

   logic                      accept;
   logic                      rsp_free;
   logic                      step_last;
   logic                      drop_now;
   logic                      is_empty_now;
   logic                      is_full_now;

   // slot cells, each but the last fed by its neighbour toward the tail
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_end
         assign nxt_id[i]  = cell_id[i];
         assign nxt_pri[i] = cell_pri[i];
      end else begin : g_mid
         assign nxt_id[i]  = cell_id[i+1];
         assign nxt_pri[i] = cell_pri[i+1];
      end

      trq_cell #(
         .INDEX          (i),
         .COUNT_W        (COUNT_W),
         .ID_WIDTH       (ID_WIDTH),
         .PRIORITY_WIDTH (PRIORITY_WIDTH)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .count    (count_ff),
         .wr_id    (req_task_id),
         .wr_pri   (req_task_priority),
         .next_id  (nxt_id[i]),
         .next_pri (nxt_pri[i]),
         .wrap_id  (cell_id[0]),
         .wrap_pri (cell_pri[0]),
         .id       (cell_id[i]),
         .pri      (cell_pri[i])
      );
   end

   // handshake
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && rsp_free);
   assign accept    = req_valid && !req_stall;

   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff == COUNT_W'(DEPTH));
   assign step_last    = (COUNT_W'(step_ff) == (len_ff - COUNT_W'(1)));
   assign drop_now     = extract_ff ? (step_ff == best_idx_ff)
                                    : (!found_ff && (cell_id[0] == key_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && !is_empty_now) begin
               if (req_opcode == OP_EXTRACT) begin
                  state_in = ST_SCAN;
               end else if (req_opcode == OP_REMOVE) begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SCAN: begin
            if (step_last) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (step_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // cell commands, counters and response contents
   always_comb begin
      cmd           = CELL_HOLD;
      count_in      = count_ff;
      len_in        = len_ff;
      step_in       = step_ff;
      best_idx_in   = best_idx_ff;
      best_id_in    = best_id_ff;
      best_pri_in   = best_pri_ff;
      found_in      = found_ff;
      extract_in    = extract_ff;
      key_in        = key_ff;
      rsp_load      = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_id_in     = '0;
      rsp_pri_in    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               len_in     = count_ff;
               step_in    = '0;
               found_in   = 1'b0;
               key_in     = req_task_id;
               extract_in = (req_opcode == OP_EXTRACT);
               unique case (req_opcode)
                  OP_ENQUEUE: begin
                     rsp_load = 1'b1;
                     if (is_full_now) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        cmd      = CELL_WRITE;
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
                  OP_DEQUEUE: begin
                     rsp_load = 1'b1;
                     if (is_empty_now) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        cmd        = CELL_DROP;
                        count_in   = count_ff - COUNT_W'(1);
                        rsp_id_in  = cell_id[0];
                        rsp_pri_in = cell_pri[0];
                     end
                  end
                  OP_PEEK: begin
                     rsp_load = 1'b1;
                     if (is_empty_now) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_id_in  = cell_id[0];
                        rsp_pri_in = cell_pri[0];
                     end
                  end
                  OP_EXTRACT: begin
                     if (is_empty_now) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end
                  end
                  OP_REMOVE: begin
                     if (is_empty_now) begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STAT_NOT_FOUND;
                     end
                  end
                  OP_COUNT: begin
                     rsp_load = 1'b1;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         // first rotation: track the highest priority, earliest wins ties
         ST_SCAN: begin
            cmd = CELL_ROTATE;
            if ((step_ff == '0) || (cell_pri[0] > best_pri_ff)) begin
               best_idx_in = step_ff;
               best_id_in  = cell_id[0];
               best_pri_in = cell_pri[0];
            end
            step_in = step_last ? '0 : step_ff + IDX_W'(1);
         end
         // second rotation: drop the chosen entry as it reaches the head
         ST_SWEEP: begin
            if (drop_now) begin
               cmd      = CELL_DROP;
               found_in = 1'b1;
               count_in = count_ff - COUNT_W'(1);
            end else begin
               cmd = CELL_ROTATE;
            end
            step_in = step_ff + IDX_W'(1);
            if (step_last) begin
               rsp_load      = 1'b1;
               rsp_status_in = (found_ff || drop_now) ? STAT_OK : STAT_NOT_FOUND;
               if (extract_ff) begin
                  rsp_id_in  = best_id_ff;
                  rsp_pri_in = best_pri_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sequencer working registers
   always_ff @(posedge clock) begin
      len_ff      <= len_in;
      step_ff     <= step_in;
      best_idx_ff <= best_idx_in;
      best_id_ff  <= best_id_in;
      best_pri_ff <= best_pri_in;
      found_ff    <= found_in;
      extract_ff  <= extract_in;
      key_ff      <= key_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_pri_ff    <= rsp_pri_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_task_id  = rsp_id_ff;
   assign rsp_out_priority = rsp_pri_ff;
   assign rsp_entry_count  = rsp_count_ff;
   assign rsp_is_empty     = (rsp_count_ff == '0);

   // checks
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= COUNT_W'(DEPTH))
   `ASSERT_IMPLIES(a_busy_no_rsp, clock, reset, state_ff != ST_IDLE, !rsp_valid_ff)
   `ASSERT_NEXT(a_scan_keeps_count, clock, reset, state_ff == ST_SCAN, count_ff == $past(count_ff))
   `ASSERT_IMPLIES(a_single_drop, clock, reset, (state_ff == ST_SWEEP) && found_ff, cmd != CELL_DROP)

endmodule

`default_nettype wire

[tb/sv/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import trq_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int DEPTH        = 16;
   localparam int PHASE_ITEMS  = 567;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int MAX_GAP      = 20;
   localparam int SCRIPT_ROWS  = 20;

   // opcodes outside the defined set, handled as count
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef struct packed {
      status_type  status;
      logic [7:0]  task_id;
      logic [7:0]  prio;
      logic [4:0]  count;
      logic        empty;
   } queue_result_type;

   typedef struct {
      logic [2:0]        op;
      logic [7:0]        id;
      logic [7:0]        prio;
      int                reps;
      bit                typed;
      queue_result_type  want;
   } directed_row_type;

   localparam queue_result_type NO_RESULT = '0;

   // directed script: repeated rows step the id by one and the priority by 37
   directed_row_type script [SCRIPT_ROWS] = '{
      '{OP_DEQUEUE, 8'h00, 8'h00,  1, 1'b1, '{STAT_EMPTY, 8'h00, 8'h00, 5'd0, 1'b1}},
      '{OP_EXTRACT, 8'h00, 8'h00,  1, 1'b1, '{STAT_EMPTY, 8'h00, 8'h00, 5'd0, 1'b1}},
      '{OP_PEEK,    8'hFF, 8'hFF,  1, 1'b1, '{STAT_EMPTY, 8'h00, 8'h00, 5'd0, 1'b1}},
      '{OP_REMOVE,  8'hFF, 8'h00,  1, 1'b1, '{STAT_NOT_FOUND, 8'h00, 8'h00, 5'd0, 1'b1}},
      '{OP_COUNT,   8'h00, 8'h00,  1, 1'b1, '{STAT_OK, 8'h00, 8'h00, 5'd0, 1'b1}},
      '{OP_SPARE_A, 8'hFF, 8'hFF,  1, 1'b1, '{STAT_OK, 8'h00, 8'h00, 5'd0, 1'b1}},
      '{OP_ENQUEUE, 8'h00, 8'h00,  1, 1'b1, '{STAT_OK, 8'h00, 8'h00, 5'd1, 1'b0}},
      '{OP_ENQUEUE, 8'hFF, 8'hFF,  1, 1'b1, '{STAT_OK, 8'h00, 8'h00, 5'd2, 1'b0}},
      '{OP_ENQUEUE, 8'h5A, 8'hFF,  1, 1'b1, '{STAT_OK, 8'h00, 8'h00, 5'd3, 1'b0}},
      '{OP_ENQUEUE, 8'h5A, 8'h01,  1, 1'b1, '{STAT_OK, 8'h00, 8'h00, 5'd4, 1'b0}},
      '{OP_PEEK,    8'h00, 8'h00,  1, 1'b1, '{STAT_OK, 8'h00, 8'h00, 5'd4, 1'b0}},
      '{OP_EXTRACT, 8'h00, 8'h00,  1, 1'b1, '{STAT_OK, 8'hFF, 8'hFF, 5'd3, 1'b0}},
      '{OP_REMOVE,  8'h5A, 8'h00,  1, 1'b1, '{STAT_OK, 8'h00, 8'h00, 5'd2, 1'b0}},
      '{OP_EXTRACT, 8'h00, 8'h00,  1, 1'b1, '{STAT_OK, 8'h5A, 8'h01, 5'd1, 1'b0}},
      '{OP_SPARE_B, 8'h00, 8'h00,  1, 1'b1, '{STAT_OK, 8'h00, 8'h00, 5'd1, 1'b0}},
      '{OP_ENQUEUE, 8'h10, 8'h30, 15, 1'b0, NO_RESULT},
      '{OP_ENQUEUE, 8'hEE, 8'h11,  1, 1'b1, '{STAT_FULL, 8'h00, 8'h00, 5'd16, 1'b0}},
      '{OP_COUNT,   8'h00, 8'h00,  1, 1'b1, '{STAT_OK, 8'h00, 8'h00, 5'd16, 1'b0}},
      '{OP_EXTRACT, 8'h00, 8'h00,  1, 1'b0, NO_RESULT},
      '{OP_REMOVE,  8'h1E, 8'h00,  1, 1'b0, NO_RESULT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = OP_COUNT;
   logic [7:0]  req_task_id = 8'h00;
   logic [7:0]  req_task_priority = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_out_task_id;
   logic [7:0]  rsp_out_priority;
   logic [4:0]  rsp_entry_count;
   logic        rsp_is_empty;

   // shadow copy of the ready queue, head in slot 0
   logic [7:0]  shadow_id [DEPTH];
   logic [7:0]  shadow_prio [DEPTH];
   int          shadow_count = 0;

   queue_result_type expected_results [$];
   int               failures = 0;
   int               cycle_count = 0;
   int               req_idle_pct = 11;
   int               rsp_stall_pct = 77;

   task_ready_queue_fifo_priority u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_task_id   (rsp_out_task_id),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // close the gap left by a removed entry
   function automatic void drop_entry(input int slot);
      for (int i = slot; i < shadow_count - 1; i++) begin
         shadow_id[i] = shadow_id[i + 1];
         shadow_prio[i] = shadow_prio[i + 1];
      end
      shadow_count--;
   endfunction

   // apply one command to the shadow queue and return its result
   function automatic queue_result_type schedule_command(input logic [2:0] op,
                                                         input logic [7:0] id,
                                                         input logic [7:0] prio);
      queue_result_type r;
      int               best;
      int               hit;
      r = NO_RESULT;
      r.status = STAT_OK;
      case (op)
         OP_ENQUEUE: begin
            if (shadow_count == DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               shadow_id[shadow_count] = id;
               shadow_prio[shadow_count] = prio;
               shadow_count++;
            end
         end
         OP_DEQUEUE, OP_PEEK: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               r.task_id = shadow_id[0];
               r.prio = shadow_prio[0];
               if (op == OP_DEQUEUE) drop_entry(0);
            end
         end
         OP_EXTRACT: begin
            if (shadow_count == 0) begin
               r.status = STAT_EMPTY;
            end else begin
               // strict compare keeps the entry nearest the head on a tie
               best = 0;
               for (int i = 1; i < shadow_count; i++)
                  if (shadow_prio[i] > shadow_prio[best]) best = i;
               r.task_id = shadow_id[best];
               r.prio = shadow_prio[best];
               drop_entry(best);
            end
         end
         OP_REMOVE: begin
            hit = -1;
            for (int i = 0; i < shadow_count; i++)
               if (hit < 0 && shadow_id[i] == id) hit = i;
            if (hit < 0) r.status = STAT_NOT_FOUND;
            else drop_entry(hit);
         end
         default: ;
      endcase
      r.count = 5'(shadow_count);
      r.empty = (shadow_count == 0);
      return r;
   endfunction

   // optional idle gap, then hold one request transaction until it is taken
   task automatic send_command(input logic [2:0] op, input logic [7:0] id,
                               input logic [7:0] prio, input bit typed,
                               input queue_result_type want);
      int               gap;
      queue_result_type predicted;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_task_id <= id;
      req_task_priority <= prio;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predicted = schedule_command(op, id, prio);
      expected_results.push_back(typed ? want : predicted);
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // compare each response transaction with the oldest expectation
   always @(posedge clock) begin : result_check
      queue_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_results.size() == 0) begin
            $error("response transaction with no expectation waiting");
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_out_task_id !== want.task_id) begin
               $error("out_task_id: expected %0d, actual %0d", want.task_id,
                      rsp_out_task_id);
               failures++;
            end
            if (rsp_out_priority !== want.prio) begin
               $error("out_priority: expected %0d, actual %0d", want.prio,
                      rsp_out_priority);
               failures++;
            end
            if (rsp_entry_count !== want.count) begin
               $error("entry_count: expected %0d, actual %0d", want.count,
                      rsp_entry_count);
               failures++;
            end
            if (rsp_is_empty !== want.empty) begin
               $error("is_empty: expected %0d, actual %0d", want.empty, rsp_is_empty);
               failures++;
            end
         end
      end
   end

   // stimulus
   initial begin
      int         sel;
      bit         filling;
      logic [2:0] op;
      logic [7:0] id;
      logic [7:0] prio;
      int         sender_idle [3];
      int         receiver_stall [3];
      sender_idle = '{11, 77, 0};
      receiver_stall = '{77, 11, 0};
      filling = 1'b1;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (script[r]) begin
         for (int k = 0; k < script[r].reps; k++) begin
            send_command(script[r].op, script[r].id + 8'(k), script[r].prio + 8'(k * 37),
                         script[r].typed, script[r].want);
         end
      end

      // random part, one idling pattern per phase
      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = sender_idle[phase];
         rsp_stall_pct = receiver_stall[phase];
         repeat (PHASE_ITEMS) begin
            // swing between filling and draining so both ends are reached
            if ($urandom_range(39) == 0) filling = !filling;
            sel = $urandom_range(99);
            if (sel < 2) begin
               op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
            end else if (sel < (filling ? 62 : 22)) begin
               op = OP_ENQUEUE;
            end else begin
               case ($urandom_range(9))
                  0, 1, 2: op = OP_EXTRACT;
                  3, 4:    op = OP_DEQUEUE;
                  5, 6, 7: op = OP_REMOVE;
                  8:       op = OP_PEEK;
                  default: op = OP_COUNT;
               endcase
            end
            // narrow id and priority pools give duplicates and ties
            if (op == OP_REMOVE && shadow_count > 0 && $urandom_range(3) != 0)
               id = shadow_id[$urandom_range(shadow_count - 1)];
            else if ($urandom_range(3) == 0)
               id = 8'($urandom_range(7));
            else
               id = 8'($urandom_range(255));
            if ($urandom_range(2) == 0) prio = 8'($urandom_range(3));
            else prio = 8'($urandom_range(255));
            send_command(op, id, prio, 1'b0, NO_RESULT);
         end
         // hold off until every response transaction has come back
         req_valid <= 1'b0;
         do @(posedge clock); while (expected_results.size() != 0);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/trq_pkg.sv
design/trq_cell.sv
design/task_ready_queue_fifo_priority.sv
tb/sv/tb.sv
